/* design/dtrb_pkg.sv */
// ----------------------------------------------------------------------------
// Direction to rotation basis: shared package
// Widths, lane assignments, shared types and helpers of the basis pipeline.
// ----------------------------------------------------------------------------
package dtrb_pkg;

  localparam int unsigned DIR_W     = 16;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned TOL_W     = 15;
  localparam int unsigned TOL_RESET = 16;
  localparam int unsigned Q_ONE     = 16384;
  localparam int unsigned Q_SHIFT   = 15;   // numerator scale 2 * Q_ONE

  localparam int unsigned SQ_W      = 64;   // square-root radicand width
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned NUM_W     = 32;
  localparam int unsigned QUO_W     = 15;
  localparam int unsigned REM_W     = 48;
  localparam int unsigned SQ_LANES  = 3;
  localparam int unsigned DIV_LANES = 8;

  localparam int unsigned APB_AW    = 2;
  localparam int unsigned APB_DW    = 32;
  localparam logic [APB_AW-1:0] ADDR_TOL = '0;

  // Square-root lanes.
  localparam int unsigned SL_S  = 0;
  localparam int unsigned SL_T  = 1;
  localparam int unsigned SL_TS = 2;

  // Divider lanes.
  localparam int unsigned LN_NX  = 0;
  localparam int unsigned LN_NY  = 1;
  localparam int unsigned LN_NZ  = 2;
  localparam int unsigned LN_R1X = 3;
  localparam int unsigned LN_R1Z = 4;
  localparam int unsigned LN_R3X = 5;
  localparam int unsigned LN_R3Y = 6;
  localparam int unsigned LN_R3Z = 7;

  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic signed [OUT_W-1:0] q14_t;
  typedef logic [TOL_W-1:0]        tol_t;
  typedef logic [SQ_W-1:0]         rad_t;
  typedef logic [ROOT_W-1:0]       root_t;
  typedef logic [NUM_W-1:0]        mag_t;
  typedef logic [QUO_W-1:0]        quo_t;
  typedef logic [REM_W-1:0]        rem_t;

  // Item data carried alongside the square-root pipeline.
  typedef struct packed {
    dir_t                    x;
    dir_t                    y;
    dir_t                    z;
    logic [NUM_W-1:0]        t;
    logic signed [NUM_W-1:0] xy;
    logic signed [NUM_W-1:0] zy;
    logic                    s_zero;
    logic                    t_zero;
  } geo_t;

  // Item flags carried alongside the divider pipeline.
  typedef struct packed {
    logic                 s_zero;
    logic                 t_zero;
    logic [DIV_LANES-1:0] neg;
  } dflag_t;

  function automatic mag_t abs_mag(logic signed [NUM_W-1:0] v);
    return v[NUM_W-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  function automatic q14_t apply_sign(quo_t q, logic neg);
    q14_t m;
    m = q14_t'(q);
    return neg ? -m : m;
  endfunction

endpackage

/* design/dtrb_chan_if.sv */
// ----------------------------------------------------------------------------
// Direction to rotation basis: channel interfaces
// Valid/ready channels for the direction input and the matrix result.
// ----------------------------------------------------------------------------
interface dtrb_in_if;
  logic                 valid;
  logic                 ready;
  dtrb_pkg::dir_t       dir_x;
  dtrb_pkg::dir_t       dir_y;
  dtrb_pkg::dir_t       dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface dtrb_out_if;
  logic           valid;
  logic           ready;
  dtrb_pkg::q14_t m11, m12, m13;
  dtrb_pkg::q14_t m21, m22, m23;
  dtrb_pkg::q14_t m31, m32, m33;

  modport source (output valid, output m11, output m12, output m13, output m21,
                  output m22, output m23, output m31, output m32, output m33,
                  input ready);
  modport sink   (input valid, input m11, input m12, input m13, input m21,
                  input m22, input m23, input m31, input m32, input m33,
                  output ready);
endinterface

/* design/dtrb_cfg.sv */
// ----------------------------------------------------------------------------
// Direction to rotation basis: configuration registers
// APB-style register file holding the near-axis tolerance.
// ----------------------------------------------------------------------------
module dtrb_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtrb_pkg::APB_AW-1:0]   paddr,
  input  logic [dtrb_pkg::APB_DW-1:0]   pwdata,
  output logic [dtrb_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output dtrb_pkg::tol_t                tol_o
);
  import dtrb_pkg::*;

  tol_t tol_r;

  assign pready = 1'b1;
  assign tol_o  = tol_r;
  assign prdata = (paddr == ADDR_TOL) ? APB_DW'(tol_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(TOL_RESET);
    end else if (psel && penable && pwrite && (paddr == ADDR_TOL)) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

endmodule

/* design/dtrb_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// Direction to rotation basis: square-root pipeline
// Integer floor square root, one result bit per register stage, several lanes.
// ----------------------------------------------------------------------------
module dtrb_sqrt_pipe #(
  parameter int unsigned LANES = dtrb_pkg::SQ_LANES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  dtrb_pkg::rad_t  [LANES-1:0]       rad_i,
  input  dtrb_pkg::geo_t                    sb_i,
  output logic                              out_valid,
  output dtrb_pkg::root_t [LANES-1:0]       root_o,
  output dtrb_pkg::geo_t                    sb_o
);
  import dtrb_pkg::*;

  localparam int unsigned STEPS = SQ_W / 2;

  rad_t [LANES-1:0] v_in    [STEPS];
  rad_t [LANES-1:0] res_in  [STEPS];
  rad_t [LANES-1:0] v_nxt   [STEPS];
  rad_t [LANES-1:0] res_nxt [STEPS];
  rad_t [LANES-1:0] v_r     [STEPS];
  rad_t [LANES-1:0] res_r   [STEPS];
  geo_t             sb_r    [STEPS];
  logic [STEPS-1:0] val_r;

  always_comb begin
    v_in[0]   = rad_i;
    res_in[0] = '0;
    for (int k = 1; k < STEPS; k++) begin
      v_in[k]   = v_r[k-1];
      res_in[k] = res_r[k-1];
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam rad_t BIT = rad_t'(1) << (SQ_W - 2 - 2 * k);
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      rad_t trial;
      logic take;
      assign trial = res_in[k][l] + BIT;
      assign take  = (v_in[k][l] >= trial);
      assign v_nxt[k][l]   = take ? (v_in[k][l] - trial) : v_in[k][l];
      assign res_nxt[k][l] = take ? ((res_in[k][l] >> 1) + BIT) : (res_in[k][l] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (en) begin
      val_r <= {val_r[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r     <= v_nxt;
      res_r   <= res_nxt;
      sb_r[0] <= sb_i;
      for (int k = 1; k < STEPS; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root_o[l] = res_r[STEPS-1][l][ROOT_W-1:0];
    end
  end

  assign out_valid = val_r[STEPS-1];
  assign sb_o      = sb_r[STEPS-1];

endmodule

/* design/dtrb_div_pipe.sv */
// ----------------------------------------------------------------------------
// Direction to rotation basis: divider pipeline
// Restoring division, one quotient bit per register stage, several lanes.
// ----------------------------------------------------------------------------
module dtrb_div_pipe #(
  parameter int unsigned LANES = dtrb_pkg::DIV_LANES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  dtrb_pkg::rem_t  [LANES-1:0]       rem_i,
  input  dtrb_pkg::root_t [LANES-1:0]       den_i,
  input  dtrb_pkg::dflag_t                  sb_i,
  output logic                              out_valid,
  output dtrb_pkg::quo_t  [LANES-1:0]       quo_o,
  output dtrb_pkg::dflag_t                  sb_o
);
  import dtrb_pkg::*;

  localparam int unsigned STEPS = QUO_W;

  rem_t  [LANES-1:0] rem_in  [STEPS];
  root_t [LANES-1:0] den_in  [STEPS];
  quo_t  [LANES-1:0] q_in    [STEPS];
  rem_t  [LANES-1:0] rem_nxt [STEPS];
  quo_t  [LANES-1:0] q_nxt   [STEPS];
  rem_t  [LANES-1:0] rem_r   [STEPS];
  root_t [LANES-1:0] den_r   [STEPS];
  quo_t  [LANES-1:0] q_r     [STEPS];
  dflag_t            sb_r    [STEPS];
  logic  [STEPS-1:0] val_r;

  always_comb begin
    rem_in[0] = rem_i;
    den_in[0] = den_i;
    q_in[0]   = '0;
    for (int k = 1; k < STEPS; k++) begin
      rem_in[k] = rem_r[k-1];
      den_in[k] = den_r[k-1];
      q_in[k]   = q_r[k-1];
    end
  end

  // The divisor is twice the root, aligned to the quotient bit of this stage.
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      rem_t dsh;
      logic take;
      assign dsh  = rem_t'({den_in[j][l], 1'b0}) << (QUO_W - 1 - j);
      assign take = (rem_in[j][l] >= dsh);
      assign rem_nxt[j][l] = take ? (rem_in[j][l] - dsh) : rem_in[j][l];
      assign q_nxt[j][l]   = take ? (q_in[j][l] | (quo_t'(1) << (QUO_W - 1 - j)))
                                  : q_in[j][l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (en) begin
      val_r <= {val_r[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r   <= rem_nxt;
      q_r     <= q_nxt;
      sb_r[0] <= sb_i;
      den_r[0] <= den_i;
      for (int k = 1; k < STEPS; k++) begin
        sb_r[k]  <= sb_r[k-1];
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign out_valid = val_r[STEPS-1];
  assign quo_o     = q_r[STEPS-1];
  assign sb_o      = sb_r[STEPS-1];

endmodule

/* design/direction_to_rotation_basis_core.sv */
// ----------------------------------------------------------------------------
// Direction to rotation basis: top level
// Throughput is one item per cycle while the output is not stalled. The depth
// is set by the 32-stage square root of the 64-bit product T*S followed by the
// 15-stage quotient pipeline.
// Reset (synchronous, rst_n low) empties every stage and sets the tolerance to 16.
// ----------------------------------------------------------------------------
module direction_to_rotation_basis_core (
  input  logic                          clk,
  input  logic                          rst_n,
  dtrb_in_if.sink                       in_ch,
  dtrb_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtrb_pkg::APB_AW-1:0]   paddr,
  input  logic [dtrb_pkg::APB_DW-1:0]   pwdata,
  output logic [dtrb_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import dtrb_pkg::*;

  localparam q14_t Q_POS = q14_t'(Q_ONE);
  localparam q14_t Q_NEG = -q14_t'(Q_ONE);

  // The whole pipeline moves as one. It advances whenever the output register
  // is empty or its contents are being taken, so a waiting result only holds
  // the pipeline for the cycles in which the sink refuses the transfer.
  logic adv;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Configuration.
  tol_t tol;

  dtrb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tol_o   (tol)
  );

  // Stage A: register the direction.
  logic a_v_r;
  dir_t ax_r, ay_r, az_r;

  // Stage B: squares and the two cross products used by row 3.
  logic                    b_v_r;
  dir_t                    bx_r, by_r, bz_r;
  logic [NUM_W-1:0]        b_xx_r, b_yy_r, b_zz_r;
  logic signed [NUM_W-1:0] b_xy_r, b_zy_r;
  logic signed [NUM_W-1:0] sq_x, sq_y, sq_z, p_xy, p_zy;

  assign sq_x = ax_r * ax_r;
  assign sq_y = ay_r * ay_r;
  assign sq_z = az_r * az_r;
  assign p_xy = ax_r * ay_r;
  assign p_zy = az_r * ay_r;

  // Stage C: squared lengths T = x*x + z*z and S = T + y*y.
  logic             c_v_r;
  geo_t             c_geo_r;
  logic [NUM_W-1:0] c_s_r;
  logic [NUM_W-1:0] t_sum, s_sum;

  assign t_sum = b_xx_r + b_zz_r;
  assign s_sum = t_sum + b_yy_r;

  // Stage D: the product T*S whose root scales row 3.
  logic             d_v_r;
  geo_t             d_geo_r;
  logic [NUM_W-1:0] d_s_r;
  rad_t             d_ts_r;
  rad_t             ts_prod;

  assign ts_prod = rad_t'(c_geo_r.t) * rad_t'(c_s_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_ch.valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r <= in_ch.dir_x;
      ay_r <= in_ch.dir_y;
      az_r <= in_ch.dir_z;

      bx_r   <= ax_r;
      by_r   <= ay_r;
      bz_r   <= az_r;
      b_xx_r <= unsigned'(sq_x);
      b_yy_r <= unsigned'(sq_y);
      b_zz_r <= unsigned'(sq_z);
      b_xy_r <= p_xy;
      b_zy_r <= p_zy;

      c_geo_r.x      <= bx_r;
      c_geo_r.y      <= by_r;
      c_geo_r.z      <= bz_r;
      c_geo_r.t      <= t_sum;
      c_geo_r.xy     <= b_xy_r;
      c_geo_r.zy     <= b_zy_r;
      c_geo_r.s_zero <= (s_sum == '0);
      c_geo_r.t_zero <= (t_sum == '0);
      c_s_r          <= s_sum;

      d_geo_r <= c_geo_r;
      d_s_r   <= c_s_r;
      d_ts_r  <= ts_prod;
    end
  end

  // Square roots of S, T and T*S, one bit per stage.
  rad_t  [SQ_LANES-1:0] sq_rad;
  root_t [SQ_LANES-1:0] sq_root;
  logic                 sq_v;
  geo_t                 sq_geo;

  always_comb begin
    sq_rad        = '0;
    sq_rad[SL_S]  = rad_t'(d_s_r);
    sq_rad[SL_T]  = rad_t'(d_geo_r.t);
    sq_rad[SL_TS] = d_ts_r;
  end

  dtrb_sqrt_pipe #(
    .LANES (SQ_LANES)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (d_v_r),
    .rad_i     (sq_rad),
    .sb_i      (d_geo_r),
    .out_valid (sq_v),
    .root_o    (sq_root),
    .sb_o      (sq_geo)
  );

  // Stage E: magnitudes, signs and starting remainders of the eight quotients.
  // Each quotient is floor((|num| * 32768 + den) / (2 * den)), which rounds
  // half away from zero once the sign is put back.
  logic                   e_v_r;
  rem_t  [DIV_LANES-1:0]  e_rem_r;
  root_t [DIV_LANES-1:0]  e_den_r;
  dflag_t                 e_flag_r;
  mag_t  [DIV_LANES-1:0]  lane_mag;
  root_t [DIV_LANES-1:0]  lane_den;
  rem_t  [DIV_LANES-1:0]  lane_rem;
  dflag_t                 lane_flag;

  always_comb begin
    lane_mag[LN_NX]  = abs_mag(NUM_W'(sq_geo.x));
    lane_mag[LN_NY]  = abs_mag(NUM_W'(sq_geo.y));
    lane_mag[LN_NZ]  = abs_mag(NUM_W'(sq_geo.z));
    lane_mag[LN_R1X] = abs_mag(NUM_W'(sq_geo.z));
    lane_mag[LN_R1Z] = abs_mag(NUM_W'(sq_geo.x));
    lane_mag[LN_R3X] = abs_mag(sq_geo.xy);
    lane_mag[LN_R3Y] = sq_geo.t;
    lane_mag[LN_R3Z] = abs_mag(sq_geo.zy);

    lane_den[LN_NX]  = sq_root[SL_S];
    lane_den[LN_NY]  = sq_root[SL_S];
    lane_den[LN_NZ]  = sq_root[SL_S];
    lane_den[LN_R1X] = sq_root[SL_T];
    lane_den[LN_R1Z] = sq_root[SL_T];
    lane_den[LN_R3X] = sq_root[SL_TS];
    lane_den[LN_R3Y] = sq_root[SL_TS];
    lane_den[LN_R3Z] = sq_root[SL_TS];

    lane_flag.s_zero      = sq_geo.s_zero;
    lane_flag.t_zero      = sq_geo.t_zero;
    lane_flag.neg[LN_NX]  = sq_geo.x[DIR_W-1];
    lane_flag.neg[LN_NY]  = sq_geo.y[DIR_W-1];
    lane_flag.neg[LN_NZ]  = sq_geo.z[DIR_W-1];
    lane_flag.neg[LN_R1X] = sq_geo.z[DIR_W-1];
    // Row 1 column 3 divides -x, so it is negative for a positive x.
    lane_flag.neg[LN_R1Z] = !sq_geo.x[DIR_W-1];
    lane_flag.neg[LN_R3X] = sq_geo.xy[NUM_W-1];
    lane_flag.neg[LN_R3Y] = 1'b1;
    lane_flag.neg[LN_R3Z] = sq_geo.zy[NUM_W-1];

    for (int l = 0; l < DIV_LANES; l++) begin
      lane_rem[l] = (rem_t'(lane_mag[l]) << Q_SHIFT) + rem_t'(lane_den[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_rem_r  <= lane_rem;
      e_den_r  <= lane_den;
      e_flag_r <= lane_flag;
    end
  end

  // Quotients, one bit per stage.
  logic                 div_v;
  quo_t [DIV_LANES-1:0] div_quo;
  dflag_t               div_flag;

  dtrb_div_pipe #(
    .LANES (DIV_LANES)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (e_v_r),
    .rem_i     (e_rem_r),
    .den_i     (e_den_r),
    .sb_i      (e_flag_r),
    .out_valid (div_v),
    .quo_o     (div_quo),
    .sb_o      (div_flag)
  );

  // Final stage: near-axis tests and selection of the matrix. A component is
  // near its target when the absolute difference lies strictly below the
  // tolerance; the downward axis is tested first and wins when both match.
  function automatic logic near_ok(q14_t n, q14_t target, tol_t bound);
    logic signed [OUT_W+1:0] d;
    logic [OUT_W+1:0]        a;
    d = (OUT_W+2)'(n) - (OUT_W+2)'(target);
    a = d[OUT_W+1] ? unsigned'(-d) : unsigned'(d);
    return a < (OUT_W+2)'(bound);
  endfunction

  q14_t n_x, n_y, n_z;
  logic near_neg, near_pos;
  q14_t m_nxt [9];
  q14_t m_r   [9];

  always_comb begin
    n_x = apply_sign(div_quo[LN_NX], div_flag.neg[LN_NX]);
    n_y = apply_sign(div_quo[LN_NY], div_flag.neg[LN_NY]);
    n_z = apply_sign(div_quo[LN_NZ], div_flag.neg[LN_NZ]);

    near_neg = near_ok(n_x, '0, tol) && near_ok(n_y, Q_NEG, tol) && near_ok(n_z, '0, tol);
    near_pos = near_ok(n_x, '0, tol) && near_ok(n_y, Q_POS, tol) && near_ok(n_z, '0, tol);

    for (int i = 0; i < 9; i++) begin
      m_nxt[i] = '0;
    end

    if (div_flag.s_zero) begin
      // A zero direction leaves the whole matrix at zero.
    end else if (near_neg || near_pos) begin
      m_nxt[0] = Q_POS;
      m_nxt[4] = near_neg ? Q_NEG : Q_POS;
      m_nxt[8] = Q_POS;
    end else begin
      m_nxt[3] = n_x;
      m_nxt[4] = n_y;
      m_nxt[5] = n_z;
      // On the vertical axis the side vector has no length; rows 1 and 3 stay zero.
      if (!div_flag.t_zero) begin
        m_nxt[0] = apply_sign(div_quo[LN_R1X], div_flag.neg[LN_R1X]);
        m_nxt[2] = apply_sign(div_quo[LN_R1Z], div_flag.neg[LN_R1Z]);
        m_nxt[6] = apply_sign(div_quo[LN_R3X], div_flag.neg[LN_R3X]);
        m_nxt[7] = apply_sign(div_quo[LN_R3Y], div_flag.neg[LN_R3Y]);
        m_nxt[8] = apply_sign(div_quo[LN_R3Z], div_flag.neg[LN_R3Z]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && div_v) begin
      m_r <= m_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.m11   = m_r[0];
  assign out_ch.m12   = m_r[1];
  assign out_ch.m13   = m_r[2];
  assign out_ch.m21   = m_r[3];
  assign out_ch.m22   = m_r[4];
  assign out_ch.m23   = m_r[5];
  assign out_ch.m31   = m_r[6];
  assign out_ch.m32   = m_r[7];
  assign out_ch.m33   = m_r[8];

`ifndef NO_ASSERTIONS
  // No quotient with a non-zero divisor can exceed one in Q1.14: every such
  // root is at least its numerator. Rows 1 and 3 have no divisor when T is zero.
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (div_v && !div_flag.s_zero) |->
      (div_quo[LN_NX] <= QUO_W'(Q_ONE)) && (div_quo[LN_NY] <= QUO_W'(Q_ONE)) &&
      (div_quo[LN_NZ] <= QUO_W'(Q_ONE)) &&
      (div_flag.t_zero ||
       ((div_quo[LN_R1X] <= QUO_W'(Q_ONE)) && (div_quo[LN_R1Z] <= QUO_W'(Q_ONE)) &&
        (div_quo[LN_R3X] <= QUO_W'(Q_ONE)) && (div_quo[LN_R3Y] <= QUO_W'(Q_ONE)) &&
        (div_quo[LN_R3Z] <= QUO_W'(Q_ONE)))))
    else $error("quotient above unity");

  // The side vector never has a Y component.
  a_m12_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (m_r[1] == '0))
    else $error("row 1 column 2 not zero");

  // A result held by the sink keeps the divider output frozen behind it.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(div_v) && $stable(div_flag))
    else $error("pipeline moved during a stall");
`endif

endmodule
